// ----- design/conv2d_sat_zero_border_assert.svh -----
// ============================================================================
// Assertion macros for the conv2d_sat_zero_border block
// Short forms for clocked implication checks with an active-low reset.
// ============================================================================
`ifndef CONV2D_SAT_ZERO_BORDER_ASSERT_SVH
`define CONV2D_SAT_ZERO_BORDER_ASSERT_SVH

// Same-cycle implication.
`define C2DSZ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define C2DSZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/c2dsz_pkg.sv -----
// ============================================================================
// c2dsz_pkg
// Shared constants and types of the streaming 2D convolution block.
// ============================================================================
package c2dsz_pkg;

    localparam int MAX_IMAGE  = 64;
    localparam int MAX_KERNEL = 5;
    localparam int KHALF      = (MAX_KERNEL - 1) / 2;
    localparam int NUM_LINES  = MAX_KERNEL - 1;

    localparam int COL_W   = $clog2(MAX_IMAGE);
    localparam int SIZE_W  = 7;
    localparam int KSIZE_W = 3;
    localparam int KH_W    = KSIZE_W - 1;
    localparam int CIDX_W  = 3;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 8;
    localparam int PROD_W  = PIX_W + COEF_W + 1;
    localparam int ROW_W   = PROD_W + $clog2(MAX_KERNEL);
    localparam int SUM_W   = ROW_W + $clog2(MAX_KERNEL);
    localparam int VALUE_W = 21;
    localparam int SAT_HIGH = 255;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [SIZE_W-1:0]  IMAGE_SIZE_RESET  = SIZE_W'(64);
    localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RESET = KSIZE_W'(3);

    localparam logic MODE_COEF  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE  = 2'd0,
        CFG_KERNEL_SIZE = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [COL_W-1:0]          out_row;
        logic [COL_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] value;
    } res_word_t;

    typedef struct packed {
        logic shift;
        logic tap_on;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 not_empty;
        logic [OUT_CNT_W-1:0] count;
    } fifo_stat_t;

endpackage

// ----- design/c2dsz_intf.sv -----
// ============================================================================
// c2dsz_in_if / c2dsz_out_if
// Valid/ready channels for input words and result words.
// ============================================================================
interface c2dsz_in_if;
    import c2dsz_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [CIDX_W-1:0]        coef_row;
    logic [CIDX_W-1:0]        coef_col;
    logic signed [COEF_W-1:0] coefficient;
    logic [PIX_W-1:0]         pixel;

    modport source (output valid, mode, coef_row, coef_col, coefficient, pixel,
                    input ready);
    modport sink   (input valid, mode, coef_row, coef_col, coefficient, pixel,
                    output ready);
endinterface

interface c2dsz_out_if;
    import c2dsz_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [COL_W-1:0]          out_row;
    logic [COL_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, out_row, out_col, value, input ready);
    modport sink   (input valid, out_row, out_col, value, output ready);
endinterface

// ----- design/c2dsz_ram.sv -----
// ============================================================================
// c2dsz_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module c2dsz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/c2dsz_cell.sv -----
// ============================================================================
// c2dsz_cell
// One window tap: holds a pixel, passes it on to the next cell, and forms the
// registered product of that pixel with its kernel weight.
// ============================================================================
module c2dsz_cell (
    input  logic                                 clk,
    input  c2dsz_pkg::cell_ctrl_t                ctrl,
    input  logic [c2dsz_pkg::PIX_W-1:0]          pix_in,
    input  logic signed [c2dsz_pkg::COEF_W-1:0]  weight,
    output logic [c2dsz_pkg::PIX_W-1:0]          pix_out,
    output logic signed [c2dsz_pkg::PROD_W-1:0]  product
);
    import c2dsz_pkg::*;

    logic [PIX_W-1:0]         pix_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // A tap outside the active kernel contributes nothing, whatever it holds.
    always_comb
    begin
        if (ctrl.tap_on)
        begin
            prod_next = PROD_W'($signed({1'b0, pix_reg})) * PROD_W'(weight);
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            pix_reg <= pix_in;
        end
        prod_reg <= prod_next;
    end

    assign pix_out = pix_reg;
    assign product = prod_reg;

endmodule

// ----- design/c2dsz_fifo.sv -----
// ============================================================================
// c2dsz_fifo
// Small result queue between the arithmetic pipeline and the output channel.
// ============================================================================
module c2dsz_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  c2dsz_pkg::res_word_t   push_word,
    input  logic                   pop,
    output c2dsz_pkg::res_word_t   head,
    output c2dsz_pkg::fifo_stat_t  stat
);
    import c2dsz_pkg::*;

    res_word_t            mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUT_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUT_PTR_W'(1);
        end
        count_next = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign head           = mem[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.count     = count_reg;

endmodule

// ----- design/conv2d_sat_zero_border.sv -----
// The result of a window-completing pixel word passes the pipeline registers and then the result queue.
// Throughput: one input word per cycle, pixels and coefficients alike, as long as results drain.
// The input stalls only while 8 result words are owed (in the pipeline or in the result queue).
// Reset clears the raster counters and the queue and sets image size 64 and kernel size 3.
// Kernel weights and line memories are undefined after reset until written; there is no clear pass.
// ============================================================================
// conv2d_sat_zero_border
// Streaming 2D correlation of a square image with an odd kernel of up to 5x5,
// built as a 5x5 array of tap cells fed by cascaded line memories.
// ============================================================================
`include "conv2d_sat_zero_border_assert.svh"

module conv2d_sat_zero_border (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [c2dsz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c2dsz_pkg::CFG_DATA_W-1:0]   cfg_data,
    c2dsz_in_if.sink                           item,
    c2dsz_out_if.source                        result
);
    import c2dsz_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] orow;
        logic [COL_W-1:0] ocol;
    } pos_t;

    // ------------------------------------------------------------------
    // Configuration and raster position
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  image_size_reg, image_size_next;
    logic [KSIZE_W-1:0] kernel_size_reg, kernel_size_next;
    logic [COL_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [SIZE_W-1:0]  n_eff;
    logic [KH_W-1:0]    k_half;
    logic               k_valid;
    logic               last_col;
    logic               last_row;

    logic               accept;
    logic               accept_pixel;
    logic               emit0;
    pos_t               pos0;

    logic [OUT_CNT_W-1:0] used_reg, used_next;
    logic                 pop;

    // Image sizes of zero read as one, sizes beyond the line length saturate.
    always_comb
    begin
        if (image_size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (image_size_reg > SIZE_W'(MAX_IMAGE))
        begin
            n_eff = SIZE_W'(MAX_IMAGE);
        end
        else
        begin
            n_eff = image_size_reg;
        end
    end

    // Only odd kernels that fit the cell array produce output; k is the
    // half width of the kernel.
    assign k_half  = kernel_size_reg[KSIZE_W-1:1];
    assign k_valid = kernel_size_reg[0] && (kernel_size_reg <= KSIZE_W'(MAX_KERNEL));

    assign item.ready   = (used_reg < OUT_CNT_W'(OUT_DEPTH));
    assign accept       = item.valid && item.ready;
    assign accept_pixel = accept && (item.mode == MODE_PIXEL);

    // A pixel at (r, c) closes the window centered at (r - k, c - k) once
    // both coordinates have reached twice the half width.
    assign emit0 = accept_pixel && k_valid
                && (row_reg >= COL_W'({k_half, 1'b0}))
                && (col_reg >= COL_W'({k_half, 1'b0}));
    assign pos0.orow = row_reg - COL_W'(k_half);
    assign pos0.ocol = col_reg - COL_W'(k_half);

    assign last_col = (SIZE_W'(col_reg) == n_eff - SIZE_W'(1));
    assign last_row = (SIZE_W'(row_reg) == n_eff - SIZE_W'(1));

    always_comb
    begin
        image_size_next  = image_size_reg;
        kernel_size_next = kernel_size_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_SIZE:  image_size_next  = cfg_data[SIZE_W-1:0];
                CFG_KERNEL_SIZE: kernel_size_next = cfg_data[KSIZE_W-1:0];
                default:         ;
            endcase
            // Any configuration write, even to an unused index, starts a
            // new frame.
            row_next = '0;
            col_next = '0;
        end
        else if (accept_pixel)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COL_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Credits: every accepted word that will produce a result holds one
    // queue slot until its result word is taken downstream.
    assign pop       = result.valid && result.ready;
    assign used_next = used_reg + OUT_CNT_W'(emit0) - OUT_CNT_W'(pop);

    // ------------------------------------------------------------------
    // Stage 1: the accepted word and the line memory read data
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic                     s1_mode_reg;
    logic [PIX_W-1:0]         s1_pixel_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [CIDX_W-1:0]        s1_crow_reg;
    logic [CIDX_W-1:0]        s1_ccol_reg;
    logic signed [COEF_W-1:0] s1_coef_reg;
    logic                     s1_emit_reg;
    pos_t                     s1_pos_reg;

    logic s2_emit_reg, s3_emit_reg, s4_emit_reg, s5_emit_reg;
    pos_t s2_pos_reg, s3_pos_reg, s4_pos_reg, s5_pos_reg;

    logic shift;
    logic coef_write;

    assign shift      = s1_valid_reg && (s1_mode_reg == MODE_PIXEL);
    assign coef_write = s1_valid_reg && (s1_mode_reg == MODE_COEF)
                     && (s1_crow_reg < CIDX_W'(MAX_KERNEL))
                     && (s1_ccol_reg < CIDX_W'(MAX_KERNEL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg  <= IMAGE_SIZE_RESET;
            kernel_size_reg <= KERNEL_SIZE_RESET;
            row_reg         <= '0;
            col_reg         <= '0;
            used_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            s1_emit_reg     <= 1'b0;
            s2_emit_reg     <= 1'b0;
            s3_emit_reg     <= 1'b0;
            s4_emit_reg     <= 1'b0;
            s5_emit_reg     <= 1'b0;
        end
        else
        begin
            image_size_reg  <= image_size_next;
            kernel_size_reg <= kernel_size_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            used_reg        <= used_next;
            s1_valid_reg    <= accept;
            s1_emit_reg     <= emit0;
            s2_emit_reg     <= s1_emit_reg;
            s3_emit_reg     <= s2_emit_reg;
            s4_emit_reg     <= s3_emit_reg;
            s5_emit_reg     <= s4_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg  <= item.mode;
        s1_pixel_reg <= item.pixel;
        s1_col_reg   <= col_reg;
        s1_crow_reg  <= item.coef_row;
        s1_ccol_reg  <= item.coef_col;
        s1_coef_reg  <= item.coefficient;
        s1_pos_reg   <= pos0;
        s2_pos_reg   <= s1_pos_reg;
        s3_pos_reg   <= s2_pos_reg;
        s4_pos_reg   <= s3_pos_reg;
        s5_pos_reg   <= s4_pos_reg;
    end

    // ------------------------------------------------------------------
    // Kernel store. A weight is written while its word sits in stage 1, so
    // pixels accepted earlier multiply with the old weight and pixels
    // accepted later with the new one.
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] kern_reg [MAX_KERNEL][MAX_KERNEL];

    always_ff @(posedge clk)
    begin
        if (coef_write)
        begin
            kern_reg[s1_crow_reg][s1_ccol_reg] <= s1_coef_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line memories. Memory L holds the row L+1 above the current one.
    // Each pixel reads its column from every memory at acceptance; in
    // stage 1 each memory takes the row that sat above it, so the rows
    // move down the cascade one column at a time.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] line_rd [NUM_LINES];
    logic [PIX_W-1:0] tap     [MAX_KERNEL];

    assign tap[0] = s1_pixel_reg;

    for (genvar L = 0; L < NUM_LINES; L++)
    begin : g_line
        logic [PIX_W-1:0] line_wdata;

        if (L == 0)
        begin : g_first
            assign line_wdata = s1_pixel_reg;
        end
        else
        begin : g_next
            assign line_wdata = line_rd[L-1];
        end

        c2dsz_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_IMAGE)
        ) u_line_ram (
            .clk   (clk),
            .we    (shift),
            .waddr (s1_col_reg),
            .wdata (line_wdata),
            .raddr (col_reg),
            .rdata (line_rd[L])
        );

        assign tap[L+1] = line_rd[L];
    end

    // ------------------------------------------------------------------
    // Cell array. Row J holds image row r - J, position P holds column
    // c - P, so the cell at (J, P) meets kernel entry (2k - J, 2k - P).
    // Each row shifts its pixels one position on every pixel word.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]         cell_pix  [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] cell_prod [MAX_KERNEL][MAX_KERNEL];

    for (genvar J = 0; J < MAX_KERNEL; J++)
    begin : g_row
        for (genvar P = 0; P < MAX_KERNEL; P++)
        begin : g_cell
            logic signed [COEF_W-1:0] opt [KHALF+1];
            logic signed [COEF_W-1:0] weight;
            logic                     tap_on;
            cell_ctrl_t               ctrl;
            logic [PIX_W-1:0]         pix_in;

            // Weight for each legal half width, from a fixed kernel entry.
            for (genvar KK = 0; KK <= KHALF; KK++)
            begin : g_opt
                if ((J <= 2 * KK) && (P <= 2 * KK))
                begin : g_in
                    assign opt[KK] = kern_reg[2 * KK - J][2 * KK - P];
                end
                else
                begin : g_out
                    assign opt[KK] = '0;
                end
            end

            always_comb
            begin
                weight = '0;
                tap_on = 1'b0;
                for (int kk = 0; kk <= KHALF; kk++)
                begin
                    if (k_valid && (k_half == KH_W'(kk)))
                    begin
                        weight = opt[kk];
                        tap_on = (J <= 2 * kk) && (P <= 2 * kk);
                    end
                end
            end

            assign ctrl.shift  = shift;
            assign ctrl.tap_on = tap_on;

            if (P == 0)
            begin : g_head
                assign pix_in = tap[J];
            end
            else
            begin : g_body
                assign pix_in = cell_pix[J][P-1];
            end

            c2dsz_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .pix_in  (pix_in),
                .weight  (weight),
                .pix_out (cell_pix[J][P]),
                .product (cell_prod[J][P])
            );
        end
    end

    // ------------------------------------------------------------------
    // Adder tree: row sums in stage 4, total and upper clamp in stage 5.
    // ------------------------------------------------------------------
    logic signed [ROW_W-1:0] rowsum_next [MAX_KERNEL];
    logic signed [ROW_W-1:0] rowsum_reg  [MAX_KERNEL];
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] clamped;
    logic signed [VALUE_W-1:0] value_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            rowsum_next[j] = '0;
            for (int p = 0; p < MAX_KERNEL; p++)
            begin
                rowsum_next[j] = rowsum_next[j] + ROW_W'(cell_prod[j][p]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            total = total + SUM_W'(rowsum_reg[j]);
        end
        clamped = (total > SUM_W'(SAT_HIGH)) ? SUM_W'(SAT_HIGH) : total;
    end

    always_ff @(posedge clk)
    begin
        rowsum_reg <= rowsum_next;
        value_reg  <= clamped[VALUE_W-1:0];
    end

    // ------------------------------------------------------------------
    // Result queue and output channel
    // ------------------------------------------------------------------
    res_word_t  push_word;
    res_word_t  head;
    fifo_stat_t fifo_stat;

    assign push_word.out_row = s5_pos_reg.orow;
    assign push_word.out_col = s5_pos_reg.ocol;
    assign push_word.value   = value_reg;

    c2dsz_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s5_emit_reg),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    assign result.valid   = fifo_stat.not_empty;
    assign result.out_row = head.out_row;
    assign result.out_col = head.out_col;
    assign result.value   = head.value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `C2DSZ_ASSERT_IMPL(a_credit_bound, clk, rst_n, 1'b1, (used_reg <= OUT_CNT_W'(OUT_DEPTH)) && (used_reg >= fifo_stat.count), "result credit count out of range")
    `C2DSZ_ASSERT_IMPL(a_no_push_full, clk, rst_n, s5_emit_reg, fifo_stat.count < OUT_CNT_W'(OUT_DEPTH), "result pushed into a full queue")
    `C2DSZ_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_we, (row_reg == '0) && (col_reg == '0), "configuration write did not restart the frame")
    `C2DSZ_ASSERT_IMPL(a_pos_in_frame, clk, rst_n, 1'b1, (SIZE_W'(col_reg) < n_eff) && (SIZE_W'(row_reg) < n_eff), "raster position outside the image")

endmodule

// ----- bench/tb_conv2d_sat_zero_border.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_conv2d_sat_zero_border
// Self-checking bench for the streaming 2D correlation block. A short table
// of directed words comes first, then random phases. Each phase sets the
// image and kernel size, loads the kernel and streams pixel words with
// random gaps and random back-pressure. Every result word is checked,
// field by field, against a predictor in the bench or a hand-typed result.
// ============================================================================
module tb_conv2d_sat_zero_border;
    import c2dsz_pkg::*;

    // Generous cap on the run length, far above the slowest legal run.
    localparam int LIMIT_CYCLES  = 600000;
    // Idle cycles allowed after the last owed result before a register write.
    // The block answers only once a word has left its pipeline registers, so this covers any word
    // still in flight that will produce nothing.
    localparam int SETTLE_CYCLES = 12;
    // Length of the one long hold-off of the result receiver.
    localparam int HOLD_CYCLES   = 150;
    // Random words to send after the directed table.
    localparam int RANDOM_ITEMS  = 1320;
    // A register index past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // One input word as the bench sees it.
    typedef struct packed {
        logic                     mode;
        logic [CIDX_W-1:0]        coef_row;
        logic [CIDX_W-1:0]        coef_col;
        logic signed [COEF_W-1:0] coefficient;
        logic [PIX_W-1:0]         pixel;
    } in_word_t;

    typedef enum logic {
        ROW_REG,
        ROW_WORD
    } row_kind_t;

    // One row of the directed table: either a register write or an input
    // word, optionally with the result word typed in by hand.
    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_data;
        in_word_t                 w;
        bit                       typed;
        res_word_t                typed_res;
    } stim_row_t;

    // How the kernel weights and pixels of a phase are chosen.
    typedef enum int {
        STYLE_RANDOM,
        STYLE_GENTLE,
        STYLE_MIN,
        STYLE_MAX
    } weight_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    c2dsz_in_if  in_ch ();
    c2dsz_out_if out_ch ();

    conv2d_sat_zero_border dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch)
    );

    // Predictor state: the kernel weights, the last MAX_KERNEL image rows,
    // the raster position of the next pixel and the two registers.
    logic signed [COEF_W-1:0] kern_w    [MAX_KERNEL][MAX_KERNEL];
    logic [PIX_W-1:0]         pix_lines [MAX_KERNEL][MAX_IMAGE];
    int                       row_pos;
    int                       col_pos;
    logic [SIZE_W-1:0]        img_reg;
    logic [KSIZE_W-1:0]       ksize_reg;

    // Result words owed by the block, oldest first.
    res_word_t   owed_results [$];
    stim_row_t   stim_table [$];
    int          err_count   = 0;
    int unsigned cycle_count = 0;
    // The sender sends back to back while this is set.
    bit          snd_calm    = 1'b0;
    // Asks the receiver process for its one long hold-off.
    bit          hold_req    = 1'b0;

    // ------------------------------------------------------------------------
    // Helpers for building words and table rows.
    // ------------------------------------------------------------------------
    function automatic in_word_t mk_coef(input int r, input int c, input int v);
        in_word_t w;
        w             = '0;
        w.mode        = MODE_COEF;
        w.coef_row    = CIDX_W'(r);
        w.coef_col    = CIDX_W'(c);
        w.coefficient = COEF_W'(v);
        return w;
    endfunction

    function automatic in_word_t mk_pix(input int p);
        in_word_t w;
        w       = '0;
        w.mode  = MODE_PIXEL;
        w.pixel = PIX_W'(p);
        return w;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t s;
        s.kind      = ROW_REG;
        s.reg_idx   = idx;
        s.reg_data  = data;
        s.w         = '0;
        s.typed     = 1'b0;
        s.typed_res = '0;
        return s;
    endfunction

    function automatic stim_row_t word_row(input in_word_t w);
        stim_row_t s;
        s.kind      = ROW_WORD;
        s.reg_idx   = '0;
        s.reg_data  = '0;
        s.w         = w;
        s.typed     = 1'b0;
        s.typed_res = '0;
        return s;
    endfunction

    function automatic stim_row_t exp_row(input in_word_t w, input int row, input int col,
                                          input int val);
        stim_row_t s;
        s                   = word_row(w);
        s.typed             = 1'b1;
        s.typed_res.out_row = COL_W'(row);
        s.typed_res.out_col = COL_W'(col);
        s.typed_res.value   = VALUE_W'(val);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    // Image size in force: zero counts as one, and anything above the
    // largest image is held at the largest image.
    function automatic int eff_size();
        int n;
        n = img_reg;
        if (n == 0) n = 1;
        if (n > MAX_IMAGE) n = MAX_IMAGE;
        return n;
    endfunction

    // Takes one accepted word, updates the predictor state and returns 1
    // when the word completes a window, with the result word in res.
    function automatic bit conv_predict(input in_word_t w, output res_word_t res);
        int n;
        int ks;
        int k;
        int rr;
        int cc;
        int br;
        int acc;
        bit hit;
        res = '0;
        hit = 1'b0;
        if (w.mode == MODE_COEF) begin
            // Indexes at or past the kernel store are dropped.
            if (w.coef_row < MAX_KERNEL && w.coef_col < MAX_KERNEL)
                kern_w[w.coef_row][w.coef_col] = w.coefficient;
            return 1'b0;
        end
        n = eff_size();
        if (row_pos >= n) row_pos = 0;
        if (col_pos >= n) col_pos = 0;
        rr = row_pos;
        cc = col_pos;
        pix_lines[rr % MAX_KERNEL][cc] = w.pixel;
        ks = ksize_reg;
        // Even or oversized kernels leave nothing but border, so no result.
        if (ks % 2 == 1 && ks <= MAX_KERNEL) begin
            k = (ks - 1) / 2;
            if (rr >= 2 * k && cc >= 2 * k) begin
                acc = 0;
                for (int x = 0; x < ks; x++) begin
                    br = (rr - 2 * k + x) % MAX_KERNEL;
                    for (int y = 0; y < ks; y++)
                        acc += int'(pix_lines[br][cc - 2 * k + y]) * int'(kern_w[x][y]);
                end
                // Clamp above only; negative sums pass through.
                if (acc > SAT_HIGH) acc = SAT_HIGH;
                res.out_row = COL_W'(rr - k);
                res.out_col = COL_W'(cc - k);
                res.value   = VALUE_W'(acc);
                hit         = 1'b1;
            end
        end
        col_pos = cc + 1;
        if (col_pos >= n) begin
            col_pos = 0;
            row_pos = rr + 1;
            if (row_pos >= n) row_pos = 0;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Random choices.
    // ------------------------------------------------------------------------

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_weight(input weight_style_t style);
        case (style)
            STYLE_GENTLE: return COEF_W'($urandom_range(0, 6) - 3);
            STYLE_MIN:    return COEF_W'(-128);
            STYLE_MAX:    return COEF_W'(127);
            default:      return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input weight_style_t style);
        // The extreme phases mostly feed full-scale pixels so that the sum
        // reaches the ends of its range.
        if ((style == STYLE_MIN || style == STYLE_MAX) && $urandom_range(0, 9) != 0)
            return PIX_W'(255);
        return PIX_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. All of them start and end at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one word after a random gap, waits for the handshake and then
    // records what the block now owes.
    task automatic send_word(input in_word_t w, input bit typed, input res_word_t typed_res);
        int        gap;
        res_word_t pred;
        bit        hit;
        gap = snd_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.mode        = w.mode;
        in_ch.coef_row    = w.coef_row;
        in_ch.coef_col    = w.coef_col;
        in_ch.coefficient = w.coefficient;
        in_ch.pixel       = w.pixel;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        // The expectation is queued on the falling edge so that it never
        // shares a time step with the result checker.
        @(negedge clk);
        hit = conv_predict(w, pred);
        if (typed)
            owed_results.push_back(typed_res);
        else if (hit)
            owed_results.push_back(pred);
    endtask

    // Stops offering words and waits until the block has nothing left.
    task automatic drain_idle();
        in_ch.valid = 1'b0;
        while (owed_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write. Any write, even to an index past the list,
    // restarts the frame.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_IMAGE_SIZE)
            img_reg = data;
        else if (idx == CFG_KERNEL_SIZE)
            ksize_reg = data[KSIZE_W-1:0];
        row_pos = 0;
        col_pos = 0;
    endtask

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. It stalls at random, has calm stretches where it
    // always takes words, and once makes its long HOLD_CYCLES hold-off so the
    // block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int calm_left;
        bit calm;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        calm_left    = 0;
        calm         = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end
            else
                calm_left--;
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Every accepted result word is matched against the
    // oldest owed word; a word with nothing owed is an error by itself.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_word_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result word: row %0d col %0d value %0d",
                         $time, out_ch.out_row, out_ch.out_col, out_ch.value);
                err_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (out_ch.out_row !== want.out_row)
                begin
                    $display("%0t: out_row mismatch: expected %0d, actual %0d",
                             $time, want.out_row, out_ch.out_row);
                    err_count++;
                end
                if (out_ch.out_col !== want.out_col)
                begin
                    $display("%0t: out_col mismatch: expected %0d, actual %0d",
                             $time, want.out_col, out_ch.out_col);
                    err_count++;
                end
                if (out_ch.value !== want.value)
                begin
                    $display("%0t: value mismatch at (%0d,%0d): expected %0d, actual %0d",
                             $time, want.out_row, want.out_col, want.value, out_ch.value);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int            ph;
        int            n_eff;
        int            ks;
        int            count;
        int            pause_at;
        int            r;
        int            random_items;
        logic [CFG_DATA_W-1:0] img_data;
        logic [CFG_DATA_W-1:0] ks_data;
        weight_style_t style;
        res_word_t     none;
        in_word_t      w;

        // Every input gets a known value at time zero.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_COEF;
        in_ch.coef_row    = '0;
        in_ch.coef_col    = '0;
        in_ch.coefficient = '0;
        in_ch.pixel       = '0;
        none              = '0;
        random_items      = 0;

        // Predictor state after reset. Kernel and line contents stay
        // unknown; the stimulus never reads an entry it has not written.
        img_reg   = IMAGE_SIZE_RESET;
        ksize_reg = KERNEL_SIZE_RESET;
        row_pos   = 0;
        col_pos   = 0;

        // Directed table. A 1x1 image with a 1x1 kernel makes every pixel
        // word produce a result at (0,0) that is just pixel times weight,
        // which shows the upper clamp, a zero and large negative sums.
        stim_table.push_back(reg_row(CFG_IMAGE_SIZE, 1));
        stim_table.push_back(reg_row(CFG_KERNEL_SIZE, 1));
        stim_table.push_back(word_row(mk_coef(0, 0, 127)));
        stim_table.push_back(exp_row(mk_pix(255), 0, 0, 255));
        stim_table.push_back(exp_row(mk_pix(0), 0, 0, 0));
        stim_table.push_back(word_row(mk_coef(0, 0, -128)));
        stim_table.push_back(exp_row(mk_pix(255), 0, 0, -32640));
        // Coefficient words whose index falls outside the store are dropped,
        // so the weight stays at -128.
        stim_table.push_back(word_row(mk_coef(7, 7, 127)));
        stim_table.push_back(exp_row(mk_pix(1), 0, 0, -128));
        stim_table.push_back(word_row(mk_coef(5, 3, 85)));
        stim_table.push_back(word_row(mk_pix(170)));
        // A 3x3 image with a 3x3 kernel has one interior pixel, reached only
        // by the last pixel of the frame. All weights at the minimum and all
        // pixels at full scale give the most negative 3x3 sum.
        stim_table.push_back(reg_row(CFG_IMAGE_SIZE, 3));
        stim_table.push_back(reg_row(CFG_KERNEL_SIZE, 3));
        for (int x = 0; x < 3; x++)
            for (int y = 0; y < 3; y++)
                stim_table.push_back(word_row(mk_coef(x, y, -128)));
        for (int i = 0; i < 8; i++)
            stim_table.push_back(word_row(mk_pix(255)));
        stim_table.push_back(exp_row(mk_pix(255), 1, 1, -293760));

        // Reset is held from time zero and released on a falling edge.
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_REG)
            begin
                drain_idle();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_data);
            end
            else
                send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].typed_res);
        end

        // Random phases. The first few pin down settings worth reaching for
        // sure; the rest are drawn at random, mostly small images.
        for (ph = 0; random_items < RANDOM_ITEMS; ph++)
        begin
            case (ph)
                0: begin img_data = 8;   ks_data = 1; style = STYLE_RANDOM; end
                1: begin img_data = 5;   ks_data = 5; style = STYLE_MIN;    end
                2: begin img_data = 64;  ks_data = 5; style = STYLE_RANDOM; end
                3: begin img_data = 0;   ks_data = 1; style = STYLE_MAX;    end
                4: begin img_data = 127; ks_data = 3; style = STYLE_GENTLE; end
                5: begin img_data = 3;   ks_data = 5; style = STYLE_RANDOM; end
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 78)
                        img_data = CFG_DATA_W'($urandom_range(1, 12));
                    else if (r < 90)
                        img_data = CFG_DATA_W'($urandom_range(13, 24));
                    else if (r < 94)
                        img_data = '0;
                    else if (r < 97)
                        img_data = CFG_DATA_W'(MAX_IMAGE);
                    else
                        img_data = CFG_DATA_W'($urandom_range(MAX_IMAGE + 1, 127));
                    r = $urandom_range(0, 99);
                    if (r < 75)
                    begin
                        ks_data = CFG_DATA_W'(2 * $urandom_range(0, 2) + 1);
                        // Bits above the kernel field are ignored.
                        if ($urandom_range(0, 4) == 0)
                            ks_data = ks_data | CFG_DATA_W'($urandom_range(1, 15) << KSIZE_W);
                    end
                    else
                    begin
                        case ($urandom_range(0, 4))
                            0:       ks_data = 0;
                            1:       ks_data = 2;
                            2:       ks_data = 4;
                            3:       ks_data = 6;
                            default: ks_data = 7;
                        endcase
                    end
                    r = $urandom_range(0, 99);
                    if (r < 55)
                        style = STYLE_RANDOM;
                    else if (r < 80)
                        style = STYLE_GENTLE;
                    else if (r < 90)
                        style = STYLE_MIN;
                    else
                        style = STYLE_MAX;
                end
            endcase

            // Registers change only with the block empty.
            drain_idle();
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_IMAGE_SIZE, img_data);
                write_reg(CFG_KERNEL_SIZE, ks_data);
            end
            else
            begin
                write_reg(CFG_KERNEL_SIZE, ks_data);
                write_reg(CFG_IMAGE_SIZE, img_data);
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));

            n_eff = eff_size();
            ks    = ksize_reg;
            snd_calm = (ph == 0) || ($urandom_range(0, 3) == 0);

            // Load the whole kernel in use before any pixel, so that no
            // window ever reads a weight that was never written.
            if (ks % 2 == 1 && ks <= MAX_KERNEL)
                for (int x = 0; x < ks; x++)
                    for (int y = 0; y < ks; y++)
                    begin
                        send_word(mk_coef(x, y, pick_weight(style)), 1'b0, none);
                        random_items++;
                    end

            // Small images get one or two whole frames and a bit more;
            // large ones only enough rows to produce some interior pixels.
            if (n_eff <= 16)
                count = n_eff * n_eff * $urandom_range(1, 2) + $urandom_range(0, 2 * n_eff);
            else
                count = n_eff * (((ks % 2 == 1 && ks <= MAX_KERNEL) ? ks : 1)
                                 + $urandom_range(1, 3));
            pause_at = (ph == 1 || $urandom_range(0, 2) == 0) ? $urandom_range(0, count - 1) : -1;

            // The first phase emits on every pixel with no random sender gaps, and
            // the receiver holds off for a long while meanwhile.
            if (ph == 0)
                hold_req = 1'b1;

            for (int i = 0; i < count; i++)
            begin
                // The run stops at the planned number of words, even in the
                // middle of a frame.
                if (random_items >= RANDOM_ITEMS)
                    break;
                // Somewhere in the stream the sender waits until every owed
                // result word has come back.
                if (i == pause_at)
                    drain_idle();
                // Stray coefficient words mid-frame, some out of range.
                if (ph != 0 && $urandom_range(0, 99) < 6)
                begin
                    w = mk_coef($urandom_range(0, 7), $urandom_range(0, 7), $urandom);
                    send_word(w, 1'b0, none);
                    random_items++;
                end
                send_word(mk_pix(pick_pixel(style)), 1'b0, none);
                random_items++;
            end
            snd_calm = 1'b0;
        end

        // Let everything drain, then report.
        drain_idle();
        if (err_count == 0 && owed_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
